FILE: sv/hsu_pkg.sv
`default_nettype none
package hsu_pkg;

  localparam int STR_W   = 17;
  localparam int DELTA_W = 18;
  localparam int CNT_W   = 32;
  localparam int RATE_W  = 20;
  localparam int EL_W    = 32;
  localparam int CFG_W   = 20;
  localparam int IN_W    = 72;
  localparam int OUT_W   = 152;

  localparam logic [STR_W-1:0] ONE_Q   = 17'h10000;
  localparam logic [STR_W-1:0] HALF_Q  = 17'h08000;
  localparam logic [STR_W-1:0] TENTH_Q = 17'd6554;

  // rate*elapsed+500 at or above 1000 * 2^21 gives x >= 32.0
  localparam logic [52:0] DEC_Y_MAX = 53'd2097152000;
  // ceil(2^41 / 1000), exact floor division for dividends below 2^31
  localparam logic [31:0] RCP_1000  = 32'd2199023256;
  localparam int          RCP_SH    = 41;

  localparam logic [2:0] ACT_REINFORCE = 3'd0;
  localparam logic [2:0] ACT_WEAKEN    = 3'd1;
  localparam logic [2:0] ACT_DECAY     = 3'd2;
  localparam logic [2:0] ACT_SET       = 3'd3;
  localparam logic [2:0] ACT_PREDICT   = 3'd4;
  localparam logic [2:0] ACT_CLEAR     = 3'd5;

  localparam logic [2:0] REG_LR    = 3'd0;
  localparam logic [2:0] REG_MIN   = 3'd1;
  localparam logic [2:0] REG_MAX   = 3'd2;
  localparam logic [2:0] REG_DECAY = 3'd3;
  localparam logic [2:0] REG_PRUNE = 3'd4;

  typedef enum logic [2:0] {
    K_REINF, K_WEAKEN, K_DECAY, K_SET, K_CLEAR, K_NONE
  } hsu_kind_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_MUL_A, OP_MUL_B, OP_APPLY, OP_DIV, OP_POST,
    OP_EXP, OP_DMUL, OP_DFIN, OP_OUT
  } hsu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_A, ST_MUL_B, ST_APPLY, ST_DIV, ST_POST,
    ST_EXP, ST_DMUL, ST_DFIN, ST_OUT
  } hsu_state_e;

  typedef struct packed {
    hsu_op_e op;
  } hsu_cmd_t;

  typedef struct packed {
    hsu_kind_e kind;
    logic      div_last;
    logic      div_run;
    logic      exp_last;
    logic      out_free;
  } hsu_sts_t;

  // round(exp(-2^(i-16)) * 2^30)
  function automatic logic [29:0] exp_tab(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'd1073725440;
      5'd1:    v = 30'd1073709056;
      5'd2:    v = 30'd1073676290;
      5'd3:    v = 30'd1073610760;
      5'd4:    v = 30'd1073479712;
      5'd5:    v = 30'd1073217664;
      5'd6:    v = 30'd1072693760;
      5'd7:    v = 30'd1071646719;
      5'd8:    v = 30'd1069555701;
      5'd9:    v = 30'd1065385899;
      5'd10:   v = 30'd1057095000;
      5'd11:   v = 30'd1040706261;
      5'd12:   v = 30'd1008687096;
      5'd13:   v = 30'd947573834;
      5'd14:   v = 30'd836230973;
      5'd15:   v = 30'd651257337;
      5'd16:   v = 30'd395007542;
      5'd17:   v = 30'd145315154;
      5'd18:   v = 30'd19666268;
      5'd19:   v = 30'd360200;
      5'd20:   v = 30'd121;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic [STR_W-1:0] clamp_str(input logic signed [19:0] v,
                                                input logic [STR_W-1:0] lo,
                                                input logic [STR_W-1:0] hi);
    logic signed [19:0] r;
    r = v;
    if (r < $signed({3'b0, lo})) r = $signed({3'b0, lo});
    if (r > $signed({3'b0, hi})) r = $signed({3'b0, hi});
    return r[STR_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

endpackage
`default_nettype wire

FILE: sv/hsu_ctrl.sv
`default_nettype none
module hsu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hsu_pkg::hsu_sts_t sts_i,
  output hsu_pkg::hsu_cmd_t cmd_o
);
  import hsu_pkg::*;

  hsu_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd_o.op = OP_MUL_A;
        state_d  = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.op = OP_MUL_B;
        state_d  = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.op = OP_APPLY;
        if (sts_i.kind == K_REINF || sts_i.kind == K_WEAKEN) begin
          state_d = ST_DIV;
        end else if (sts_i.kind == K_DECAY) begin
          state_d = ST_EXP;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (sts_i.div_last) state_d = ST_POST;
      end
      ST_POST: begin
        cmd_o.op = OP_POST;
        state_d  = ST_OUT;
      end
      ST_EXP: begin
        cmd_o.op = OP_EXP;
        if (sts_i.exp_last) state_d = ST_DMUL;
      end
      ST_DMUL: begin
        cmd_o.op = OP_DMUL;
        state_d  = ST_DFIN;
      end
      ST_DFIN: begin
        cmd_o.op = OP_DFIN;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/hsu_dp.sv
`default_nettype none
module hsu_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hsu_pkg::hsu_cmd_t            cmd_i,
  output hsu_pkg::hsu_sts_t            sts_o,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [hsu_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic [hsu_pkg::IN_W-1:0]     in_data_i,
  output logic [hsu_pkg::OUT_W-1:0]    out_data_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i
);
  import hsu_pkg::*;

  // configuration
  logic [STR_W-1:0]  lr_q, min_q, max_q, thr_q;
  logic [RATE_W-1:0] rate_q;

  // item
  hsu_kind_e         kind_q, kind_in;
  logic [STR_W-1:0]  s_q, amt_q, amt_in;
  logic [EL_W-1:0]   el_q;

  // statistics
  logic [CNT_W-1:0]        rt_q, wt_q, dt_q;
  logic signed [DELTA_W-1:0] mean_q;

  // working registers
  logic signed [35:0]  p1_q;
  logic signed [53:0]  p_q;
  logic [33:0]         dvd_q;
  logic [33:0]         dvs_q;
  logic [34:0]         rem_q;
  logic [5:0]          cnt_q;
  logic                dneg_q;
  logic [20:0]         x_q;
  logic [30:0]         acc_q;
  logic [4:0]          idx_q;
  logic [STR_W-1:0]    pre_q, nv_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic [OUT_W-1:0]    out_q;
  logic                ovalid_q;

  // input decode
  logic [2:0] act_in;
  logic       pr_in, oc_in;
  always_comb begin
    act_in  = in_data_i[2:0];
    pr_in   = in_data_i[69];
    oc_in   = in_data_i[70];
    amt_in  = in_data_i[36:20];
    kind_in = K_NONE;
    unique case (act_in)
      ACT_REINFORCE: kind_in = K_REINF;
      ACT_WEAKEN:    kind_in = K_WEAKEN;
      ACT_DECAY:     kind_in = K_DECAY;
      ACT_SET:       kind_in = K_SET;
      ACT_CLEAR:     kind_in = K_CLEAR;
      ACT_PREDICT: begin
        if (pr_in && oc_in) begin
          kind_in = K_REINF;
          amt_in  = ONE_Q;
        end else if (pr_in) begin
          kind_in = K_WEAKEN;
          amt_in  = HALF_Q;
        end else if (oc_in) begin
          kind_in = K_REINF;
          amt_in  = TENTH_Q;
        end
      end
      default: kind_in = K_NONE;
    endcase
  end

  // multiplies
  logic signed [17:0] diff;
  logic [STR_W-1:0]   r_val;
  logic signed [35:0] prod_a;
  logic signed [53:0] prod_b;
  logic [35:0]        dec_lo, dec_hi;
  always_comb begin
    diff   = (kind_q == K_REINF) ? $signed({1'b0, ONE_Q}) - $signed({1'b0, s_q})
                                 : $signed({1'b0, s_q});
    r_val  = (amt_q > ONE_Q) ? ONE_Q : amt_q;
    prod_a = $signed({1'b0, lr_q}) * diff;
    prod_b = p1_q * $signed({1'b0, r_val});
    dec_lo = rate_q * el_q[15:0];
    dec_hi = rate_q * el_q[31:16];
  end

  // reinforce / weaken / set apply
  logic signed [53:0] num;
  logic [53:0]        mag, mag_r;
  logic [21:0]        qr, qr_n;
  logic signed [17:0] rw_delta, set_delta;
  logic signed [19:0] v20;
  logic [STR_W-1:0]   rw_nv, set_nv;
  logic [CNT_W-1:0]   rt_nx, wt_nx;
  logic [32:0]        n_sum;
  logic signed [18:0] md;
  logic [18:0]        md_mag;
  logic [33:0]        dd;
  always_comb begin
    num   = (kind_q == K_WEAKEN) ? -p_q : p_q;
    mag   = num[53] ? 54'(-num) : 54'(num);
    mag_r = mag + 54'h80000000;
    qr    = mag_r[53:32];
    qr_n  = ~qr + 22'd1;
    if (!num[53]) begin
      rw_delta = (qr > 22'd131071) ? 18'sh1FFFF : $signed(qr[17:0]);
    end else begin
      rw_delta = (qr > 22'd131072) ? 18'sh20000 : $signed(qr_n[17:0]);
    end
    v20    = $signed({3'b0, s_q}) + $signed({{2{rw_delta[17]}}, rw_delta});
    rw_nv  = clamp_str(v20, min_q, max_q);
    rt_nx  = (kind_q == K_REINF) ? sat_inc(rt_q) : rt_q;
    wt_nx  = (kind_q == K_WEAKEN) ? sat_inc(wt_q) : wt_q;
    n_sum  = {1'b0, rt_nx} + {1'b0, wt_nx};
    md     = $signed({rw_delta[17], rw_delta}) - $signed({mean_q[17], mean_q});
    md_mag = md[18] ? 19'(-md) : 19'(md);
    dd     = {15'b0, md_mag} + {2'b0, n_sum[32:1]};
    set_delta = $signed({1'b0, amt_q}) - $signed({1'b0, s_q});
    set_nv    = clamp_str($signed({3'b0, amt_q}), min_q, max_q);
  end

  // bit-serial divider for the running mean
  logic [34:0] trial;
  logic        ge;
  always_comb begin
    trial = {rem_q[33:0], dvd_q[33]};
    ge    = trial >= {1'b0, dvs_q};
  end

  // mean update
  logic [33:0]        quo;
  logic signed [35:0] msum;
  logic signed [DELTA_W-1:0] mean_nx;
  always_comb begin
    quo  = dvd_q;
    msum = $signed({{18{mean_q[17]}}, mean_q}) +
           (dneg_q ? -$signed({2'b0, quo}) : $signed({2'b0, quo}));
    if (msum > 36'sd131071) mean_nx = 18'sh1FFFF;
    else if (msum < -36'sd131072) mean_nx = 18'sh20000;
    else mean_nx = msum[17:0];
  end

  // rate*elapsed/1000 by reciprocal multiply; only needed below the 32.0 cutoff
  logic        x_big;
  logic [62:0] x_rcp;
  always_comb begin
    x_big = (p_q[52:0] >= DEC_Y_MAX);
    x_rcp = 63'(p_q[30:0]) * 63'(RCP_1000);
  end

  // exponential and final decay product
  logic [60:0] ep;
  logic [47:0] dm;
  always_comb begin
    ep = acc_q * exp_tab(idx_q) + 61'h20000000;
    dm = s_q * acc_q + 48'h20000000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q     <= 17'd6554;
      min_q    <= '0;
      max_q    <= ONE_Q;
      rate_q   <= 20'd655;
      thr_q    <= 17'd655;
      rt_q     <= '0;
      wt_q     <= '0;
      dt_q     <= '0;
      mean_q   <= '0;
      kind_q   <= K_NONE;
      cnt_q    <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LR:    lr_q   <= cfg_wdata_i[STR_W-1:0];
          REG_MIN:   min_q  <= cfg_wdata_i[STR_W-1:0];
          REG_MAX:   max_q  <= cfg_wdata_i[STR_W-1:0];
          REG_DECAY: rate_q <= cfg_wdata_i;
          REG_PRUNE: thr_q  <= cfg_wdata_i[STR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_OUT) begin
        ovalid_q <= 1'b1;
      end else if (ovalid_q && out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_LOAD: begin
          kind_q <= kind_in;
          s_q    <= in_data_i[19:3];
          amt_q  <= amt_in;
          el_q   <= in_data_i[68:37];
        end
        OP_MUL_A: begin
          p1_q <= prod_a;
          p_q  <= $signed({18'b0, dec_lo});
        end
        OP_MUL_B: begin
          if (kind_q == K_DECAY) begin
            p_q <= p_q + $signed({2'b0, dec_hi, 16'b0}) + 54'sd500;
          end else begin
            p_q <= prod_b;
          end
        end
        OP_APPLY: begin
          rem_q <= '0;
          case (kind_q) inside
            K_REINF, K_WEAKEN: begin
              delta_q <= rw_delta;
              nv_q    <= rw_nv;
              rt_q    <= rt_nx;
              wt_q    <= wt_nx;
              dneg_q  <= md[18];
              dvd_q   <= dd;
              dvs_q   <= {1'b0, n_sum};
              cnt_q   <= 6'd34;
            end
            K_DECAY: begin
              idx_q <= '0;
              if (x_big) begin
                x_q   <= '0;
                acc_q <= '0;
              end else begin
                x_q   <= x_rcp[RCP_SH+20:RCP_SH];
                acc_q <= 31'h40000000;
              end
            end
            K_SET: begin
              delta_q <= set_delta;
              nv_q    <= set_nv;
            end
            K_CLEAR: begin
              rt_q    <= '0;
              wt_q    <= '0;
              dt_q    <= '0;
              mean_q  <= '0;
              delta_q <= '0;
              nv_q    <= s_q;
            end
            default: begin
              delta_q <= '0;
              nv_q    <= s_q;
            end
          endcase
        end
        OP_DIV: begin
          cnt_q <= cnt_q - 6'd1;
          rem_q <= ge ? trial - {1'b0, dvs_q} : trial;
          dvd_q <= {dvd_q[32:0], ge};
        end
        OP_POST: begin
          mean_q <= mean_nx;
        end
        OP_EXP: begin
          if (x_q[idx_q]) acc_q <= ep[60:30];
          idx_q <= idx_q + 5'd1;
        end
        OP_DMUL: begin
          pre_q <= dm[46:30];
        end
        OP_DFIN: begin
          delta_q <= $signed({1'b0, pre_q}) - $signed({1'b0, s_q});
          nv_q    <= clamp_str($signed({3'b0, pre_q}), min_q, max_q);
          dt_q    <= sat_inc(dt_q);
        end
        OP_OUT: begin
          out_q <= {2'b0, mean_q, dt_q, wt_q, rt_q, (nv_q < thr_q), delta_q, nv_q};
        end
        default: ;
      endcase
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = ovalid_q;

  always_comb begin
    sts_o.kind     = kind_q;
    sts_o.div_last = (cnt_q == 6'd1);
    sts_o.div_run  = (cnt_q != 6'd0);
    sts_o.exp_last = (idx_q == 5'd20);
    sts_o.out_free = !ovalid_q || out_ready_i;
  end

endmodule
`default_nettype wire

FILE: sv/hebbian_strength_update_top.sv
`default_nettype none
// Edge strength update engine, one item at a time. Set, reset-stats and no-op actions
// go straight from the apply step to the output; reinforce and weaken run a 34-step
// bit-serial divider that forms the running mean of delta, and decay uses a reciprocal
// multiply to scale rate*elapsed by 1/1000, then 21 steps of the exp-table multiplier.
// The next item is taken once the current one reaches the output register,
// which holds the result while downstream stalls.
module hebbian_strength_update_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [hsu_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // action[2:0], strength[19:3], amount[36:20], elapsed_ms[68:37],
  // predicted[69], occurred[70], zero fill
  input  logic [hsu_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // updated strength[16:0], delta[34:17], prune_flag[35], reinforce_count[67:36],
  // weaken_count[99:68], decay_count[131:100], average_delta[149:132], zero fill
  output logic [hsu_pkg::OUT_W-1:0] m_axis_tdata
);
  import hsu_pkg::*;

  hsu_cmd_t cmd;
  hsu_sts_t sts;

  hsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hsu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .out_data_o  (m_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_run |-> !s_axis_tready)
    else $error("ready raised while divider running");

endmodule
`default_nettype wire
